// ===== rtl/brs_pkg.sv =====
// Shared constants and types of the block reverse stream.
package brs_pkg;

	localparam int MAX_GROUP = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd1;
	localparam int JOB_CNT_W = 7;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic                 bank;
		logic [JOB_CNT_W-1:0] count;
		logic                 reverse;
		logic                 list_end;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

endpackage

// ===== rtl/brs_job_queue.sv =====
// Short queue of group jobs between the front and the back.
module brs_job_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  brs_pkg::job_t push_job,
	output logic         full,
	input  logic         pop,
	output brs_pkg::job_t pop_job,
	output logic         not_empty
);

	localparam int PTR_W = $clog2(brs_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(brs_pkg::QUEUE_DEPTH + 1);

	brs_pkg::job_t entry_q [brs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(brs_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_job = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(brs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(brs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/brs_front.sv =====
// Front part: takes requests, fills the two group banks and issues jobs.
module brs_front #(
	parameter int MAX_GROUP = brs_pkg::MAX_GROUP,
	parameter int DATA_WIDTH = brs_pkg::DATA_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [brs_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [DATA_WIDTH-1:0]      value,
	input  logic                              list_last,
	output logic                              wr_en,
	output logic [$clog2(MAX_GROUP):0]        wr_addr,
	output logic [DATA_WIDTH-1:0]             wr_data,
	output logic                              job_push,
	output brs_pkg::job_t                     job_out,
	input  logic                              job_full,
	input  brs_pkg::release_t                 rel
);

	localparam int IDX_W = $clog2(MAX_GROUP);
	localparam int CNT_W = $clog2(MAX_GROUP + 1);

	logic [brs_pkg::CFG_W-1:0] group_size_q;
	logic [CNT_W-1:0] fill_q;
	logic bank_q;
	logic [1:0] busy_q;
	logic [1:0] busy_d;
	logic [CNT_W-1:0] fill_next;
	logic [CNT_W-1:0] k_eff;
	logic accept;
	logic complete;

	always_comb begin
		if (32'(group_size_q) > MAX_GROUP) begin
			k_eff = CNT_W'(MAX_GROUP);
		end else if (group_size_q == '0) begin
			k_eff = CNT_W'(1);
		end else begin
			k_eff = CNT_W'(group_size_q);
		end
	end

	assign in_ready = !busy_q[bank_q] && !job_full;
	assign accept = in_valid && in_ready;
	assign fill_next = fill_q + CNT_W'(1);
	assign complete = (fill_next >= k_eff);

	assign wr_en = accept;
	assign wr_addr = {bank_q, fill_q[IDX_W-1:0]};
	assign wr_data = value;

	assign job_push = accept && (complete || list_last);
	assign job_out.bank = bank_q;
	assign job_out.count = brs_pkg::JOB_CNT_W'(fill_next);
	assign job_out.reverse = complete;
	assign job_out.list_end = list_last;

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (job_push) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= brs_pkg::GROUP_SIZE_RESET;
			fill_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (cfg_we) begin
				group_size_q <= cfg_data;
			end
			if (accept) begin
				if (job_push) begin
					fill_q <= '0;
					bank_q <= ~bank_q;
				end else begin
					fill_q <= fill_next;
				end
			end
			busy_q <= busy_d;
		end
	end

endmodule

// ===== rtl/brs_back.sv =====
// Back part: holds the group memory and drains each job to the output register.
module brs_back #(
	parameter int MAX_GROUP = brs_pkg::MAX_GROUP,
	parameter int DATA_WIDTH = brs_pkg::DATA_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [$clog2(MAX_GROUP):0]        wr_addr,
	input  logic [DATA_WIDTH-1:0]             wr_data,
	input  logic                              job_valid,
	input  brs_pkg::job_t                     job_in,
	output logic                              job_pop,
	output brs_pkg::release_t                 rel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [DATA_WIDTH-1:0]      out_value,
	output logic                              run_last,
	output logic                              list_end
);

	localparam int IDX_W = $clog2(MAX_GROUP);
	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam int DEPTH = 2 ** (IDX_W + 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic active_q;
	brs_pkg::job_t job_q;
	logic [CNT_W-1:0] pos_q;
	logic out_valid_q;
	logic signed [DATA_WIDTH-1:0] out_value_q;
	logic run_last_q;
	logic list_end_q;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] rd_idx;
	logic [IDX_W:0] rd_addr;
	logic last_item;
	logic adv;
	logic finish;

	assign cnt = CNT_W'(job_q.count);
	assign last_item = (pos_q == cnt - CNT_W'(1));
	assign rd_idx = job_q.reverse ? (cnt - CNT_W'(1) - pos_q) : pos_q;
	assign rd_addr = {job_q.bank, rd_idx[IDX_W-1:0]};
	assign adv = active_q && (!out_valid_q || out_ready);
	assign finish = adv && last_item;
	assign job_pop = job_valid && (!active_q || finish);
	assign rel.valid = finish;
	assign rel.bank = job_q.bank;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign run_last = run_last_q;
	assign list_end = list_end_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= mem[rd_addr];
			run_last_q <= last_item;
			list_end_q <= last_item && job_q.list_end;
		end
		if (job_pop) begin
			job_q <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (job_pop) begin
				active_q <= 1'b1;
				pos_q <= '0;
			end else begin
				if (finish) begin
					active_q <= 1'b0;
				end
				if (adv) begin
					pos_q <= pos_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/block_reverse_stream.sv =====
// Top level of the block reverse stream: front, job queue and back.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_ready   value, list_last
//   out      result     out_valid / out_ready out_value, run_last, list_end
//   cfg      write      cfg_we                cfg_data (group size)
//
// An input request is written to one of two group banks.
// A finished group is drained one result per cycle, unless out_ready holds it back, from the bank memory through
// the output register, while the front fills the other bank.
// The first result of a group passes from the request that completes it through the job queue,
// the job register in the back and the output register, where the bank is read.
// The front stalls only while both banks still hold groups that are not drained.
// Reset clears the group size to one, the fill count, the queue and all valid flags.
module block_reverse_stream #(
	parameter int MAX_GROUP = brs_pkg::MAX_GROUP,
	parameter int DATA_WIDTH = brs_pkg::DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [brs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [DATA_WIDTH-1:0]  value,
	input  logic                          list_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DATA_WIDTH-1:0]  out_value,
	output logic                          run_last,
	output logic                          list_end
);

	logic wr_en;
	logic [$clog2(MAX_GROUP):0] wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_valid;
	brs_pkg::job_t push_job;
	brs_pkg::job_t pop_job;
	brs_pkg::release_t rel;

	brs_front #(
		.MAX_GROUP(MAX_GROUP),
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.list_last(list_last),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_push(job_push),
		.job_out(push_job),
		.job_full(job_full),
		.rel(rel)
	);

	brs_job_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_job(push_job),
		.full(job_full),
		.pop(job_pop),
		.pop_job(pop_job),
		.not_empty(job_valid)
	);

	brs_back #(
		.MAX_GROUP(MAX_GROUP),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_valid(job_valid),
		.job_in(pop_job),
		.job_pop(job_pop),
		.rel(rel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_value(out_value),
		.run_last(run_last),
		.list_end(list_end)
	);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the block reverse stream: directed and random lists against a group model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_GROUP = brs_pkg::MAX_GROUP;
	localparam int DATA_WIDTH = brs_pkg::DATA_WIDTH;
	localparam int CFG_W = brs_pkg::CFG_W;

	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] val;
		logic                         run_last;
		logic                         list_end;
	} reordered_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [CFG_W-1:0]             cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic signed [DATA_WIDTH-1:0] value;
	logic                         list_last;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [DATA_WIDTH-1:0] out_value;
	logic                         run_last;
	logic                         list_end;

	reordered_t                   pending_results[$];
	logic signed [DATA_WIDTH-1:0] held_vals[MAX_GROUP];
	int unsigned                  held_count;
	int unsigned                  group_size_model;
	int unsigned                  send_idle_pct;
	int unsigned                  recv_idle_pct;
	int unsigned                  fail_count = 0;

	block_reverse_stream DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.list_last (list_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_value (out_value),
		.run_last  (run_last),
		.list_end  (list_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void reorder_request(input logic signed [DATA_WIDTH-1:0] v,
			input logic lst);
		int unsigned k;
		int unsigned n;
		reordered_t r;
		k = group_size_model;
		if (k < 1) k = 1;
		if (k > MAX_GROUP) k = MAX_GROUP;
		if (held_count < MAX_GROUP) begin
			held_vals[held_count] = v;
			held_count++;
		end
		n = held_count;
		if (n >= k) begin
			for (int unsigned i = 0; i < n; i++) begin
				r.val = held_vals[n - 1 - i];
				r.run_last = (i + 1 == n);
				r.list_end = (i + 1 == n) && lst;
				pending_results.push_back(r);
			end
			held_count = 0;
		end else if (lst) begin
			for (int unsigned i = 0; i < n; i++) begin
				r.val = held_vals[i];
				r.run_last = (i + 1 == n);
				r.list_end = (i + 1 == n);
				pending_results.push_back(r);
			end
			held_count = 0;
		end
	endfunction

	function automatic logic [CFG_W-1:0] pick_group_size();
		int unsigned r;
		r = $urandom_range(15);
		case (r)
			0: return 5'd0;
			1: return 5'd1;
			2: return CFG_W'($urandom_range(17, 31));
			3: return 5'd16;
			default: return CFG_W'($urandom_range(2, 8));
		endcase
	endfunction

	task automatic send_value(input logic signed [DATA_WIDTH-1:0] v, input logic lst);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		list_last <= lst;
		do @(posedge clk); while (!in_ready);
		reorder_request(v, lst);
	endtask

	// The block must be idle: no result owed and any held request already stored.
	task automatic write_group_size(input logic [CFG_W-1:0] sz);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
		group_size_model = sz;
	endtask

	task automatic check_result();
		reordered_t e;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result value %0d run_last %0b list_end %0b",
				$time, out_value, run_last, list_end);
			fail_count++;
		end else begin
			e = pending_results.pop_front();
			if (out_value !== e.val) begin
				$display("%0t: out_value expected %0d actual %0d", $time, e.val, out_value);
				fail_count++;
			end
			if (run_last !== e.run_last) begin
				$display("%0t: run_last expected %0b actual %0b", $time, e.run_last, run_last);
				fail_count++;
			end
			if (list_end !== e.list_end) begin
				$display("%0t: list_end expected %0b actual %0b", $time, e.list_end, list_end);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if (out_valid && out_ready) check_result();
		end
	end

	task automatic test_pass_through();
		write_group_size(5'd1);
		send_value(32'sh7fffffff, 1'b0);
		send_value(32'sh80000000, 1'b1);
		write_group_size(5'd0);
		send_value(-32'sd1, 1'b0);
		send_value(32'sd0, 1'b1);
	endtask

	task automatic test_reverse_and_tail();
		write_group_size(5'd3);
		send_value(32'sd10, 1'b0);
		send_value(32'sd11, 1'b0);
		send_value(32'sd12, 1'b0);
		send_value(32'sd13, 1'b0);
		send_value(32'sd14, 1'b1);
	endtask

	task automatic test_oversized_group();
		write_group_size(5'd31);
		for (int i = 0; i < MAX_GROUP; i++) send_value(100 + i, i == MAX_GROUP - 1);
	endtask

	task automatic test_shrink_mid_fill();
		write_group_size(5'd5);
		send_value(32'sd21, 1'b0);
		send_value(32'sd22, 1'b0);
		write_group_size(5'd0);
		send_value(32'sd23, 1'b0);
	endtask

	task automatic test_random_lists(input int unsigned item_goal, input int unsigned snd_idle,
			input int unsigned rcv_idle);
		int unsigned sent;
		int unsigned len;
		int unsigned k;
		int unsigned split;
		logic [CFG_W-1:0] sz;
		logic signed [DATA_WIDTH-1:0] v;
		send_idle_pct = snd_idle;
		recv_idle_pct = rcv_idle;
		sent = 0;
		while (sent < item_goal) begin
			sz = pick_group_size();
			write_group_size(sz);
			k = (sz < 2) ? 1 : ((sz > MAX_GROUP) ? MAX_GROUP : sz);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(3) == 0) len = k * $urandom_range(1, 3);
				else len = $urandom_range(1, 3 * k + 1);
				split = ($urandom_range(7) == 0) ? $urandom_range(1, len) : 0;
				for (int unsigned i = 1; i <= len; i++) begin
					if (i == split) write_group_size(pick_group_size());
					case ($urandom_range(15))
						0: v = 32'sh7fffffff;
						1: v = 32'sh80000000;
						2: v = 32'sd0;
						3: v = -32'sd1;
						default: v = $urandom;
					endcase
					send_value(v, i == len);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		value = '0;
		list_last = 1'b0;
		held_count = 0;
		group_size_model = 1;
		send_idle_pct = 0;
		recv_idle_pct = 30;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pass_through();
		test_reverse_and_tail();
		test_oversized_group();
		test_shrink_mid_fill();
		test_random_lists(140, 18, 57);
		test_random_lists(140, 57, 18);
		test_random_lists(140, 0, 0);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#1ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
